[hw/rtl/sjis_csv_field_splitter_assert.svh]
// Assertion macros used by the checker of the field splitter.
`ifndef SJIS_CSV_FIELD_SPLITTER_ASSERT_SVH
`define SJIS_CSV_FIELD_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("field splitter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("field splitter assertion failed");

`endif

[hw/rtl/sjiscsv_pkg.sv]
// Package with the types and constants of the Shift-JIS CSV field splitter.
package sjiscsv_pkg;

    localparam logic [7:0] LEAD_LOW_A  = 8'h80;
    localparam logic [7:0] LEAD_HIGH_A = 8'h9F;
    localparam logic [7:0] LEAD_LOW_B  = 8'hE0;
    localparam logic [7:0] LEAD_HIGH_B = 8'hFF;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] WIDE_LEAD   = 8'h81;
    localparam logic [7:0] WIDE_SPACE  = 8'h40;

    localparam int QUEUE_DEPTH = 3;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_CONTENT,
        PH_QUOTED,
        PH_AFTER
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       record_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       keep;
        logic       restart;
        logic       field_end;
        logic       record_end;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } scan_out_t;

endpackage

[hw/rtl/scfs_scanner.sv]
// Byte classifier and field state registers of the field splitter.
module scfs_scanner
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  sjiscsv_pkg::in_item_t  item,
    output sjiscsv_pkg::scan_out_t scan
);

    sjiscsv_pkg::phase_t phase_reg;
    sjiscsv_pkg::phase_t phase_next;
    logic                quote_reg;
    logic                quote_next;
    logic                literal_reg;
    logic                literal_next;
    logic                held_reg;
    logic                held_next;

    logic       [7:0] b;
    logic             last;
    logic             keep;
    logic             rst;
    logic             fend;
    logic             none;
    logic             extra;
    logic             is_lead;
    sjiscsv_pkg::out_item_t main_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sjiscsv_pkg::PH_BLANK;
            quote_reg   <= 1'b0;
            literal_reg <= 1'b0;
            held_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            quote_reg   <= quote_next;
            literal_reg <= literal_next;
            held_reg    <= held_next;
        end
    end

    always_comb
    begin
        b            = item.in_byte;
        last         = item.record_last;
        keep         = 1'b0;
        rst          = 1'b0;
        fend         = last;
        none         = 1'b0;
        extra        = 1'b0;
        phase_next   = phase_reg;
        quote_next   = quote_reg;
        literal_next = literal_reg;
        held_next    = held_reg;
        is_lead      = ((b >= sjiscsv_pkg::LEAD_LOW_A) && (b <= sjiscsv_pkg::LEAD_HIGH_A))
                    || ((b >= sjiscsv_pkg::LEAD_LOW_B) && (b <= sjiscsv_pkg::LEAD_HIGH_B));

        if (held_reg)
        begin
            held_next = 1'b0;
            if (b != sjiscsv_pkg::WIDE_SPACE)
            begin
                extra      = 1'b1;
                keep       = 1'b1;
                phase_next = sjiscsv_pkg::PH_CONTENT;
            end
        end
        else if (literal_reg)
        begin
            literal_next = 1'b0;
            keep = (phase_reg == sjiscsv_pkg::PH_CONTENT) || (phase_reg == sjiscsv_pkg::PH_QUOTED);
        end
        else if (is_lead || (b == sjiscsv_pkg::CHAR_BSLASH))
        begin
            if ((phase_reg == sjiscsv_pkg::PH_BLANK) && (b == sjiscsv_pkg::WIDE_LEAD) && !last)
            begin
                held_next = 1'b1;
                none      = 1'b1;
            end
            else
            begin
                if (phase_reg == sjiscsv_pkg::PH_BLANK)
                begin
                    phase_next = sjiscsv_pkg::PH_CONTENT;
                end
                keep = (phase_next == sjiscsv_pkg::PH_CONTENT)
                    || (phase_next == sjiscsv_pkg::PH_QUOTED);
                literal_next = 1'b1;
            end
        end
        else if ((b == sjiscsv_pkg::CHAR_COMMA) && !quote_reg)
        begin
            fend       = 1'b1;
            phase_next = sjiscsv_pkg::PH_BLANK;
        end
        else if (b == sjiscsv_pkg::CHAR_QUOTE)
        begin
            quote_next = !quote_reg;
            if ((phase_reg == sjiscsv_pkg::PH_BLANK) || (phase_reg == sjiscsv_pkg::PH_CONTENT))
            begin
                rst        = 1'b1;
                phase_next = sjiscsv_pkg::PH_QUOTED;
            end
            else if (phase_reg == sjiscsv_pkg::PH_QUOTED)
            begin
                phase_next = sjiscsv_pkg::PH_AFTER;
            end
        end
        else if ((phase_reg == sjiscsv_pkg::PH_BLANK)
              && ((b == sjiscsv_pkg::CHAR_SPACE) || (b == sjiscsv_pkg::CHAR_TAB)))
        begin
            keep = 1'b0;
        end
        else
        begin
            if (phase_reg == sjiscsv_pkg::PH_BLANK)
            begin
                phase_next = sjiscsv_pkg::PH_CONTENT;
            end
            keep = (phase_next == sjiscsv_pkg::PH_CONTENT)
                || (phase_next == sjiscsv_pkg::PH_QUOTED);
        end

        if (last)
        begin
            phase_next   = sjiscsv_pkg::PH_BLANK;
            quote_next   = 1'b0;
            literal_next = 1'b0;
            held_next    = 1'b0;
        end

        main_item.out_byte   = b;
        main_item.keep       = keep;
        main_item.restart    = rst;
        main_item.field_end  = fend;
        main_item.record_end = last;
        main_item.run_last   = 1'b1;

        scan.second = main_item;
        if (none)
        begin
            scan.count = 2'd0;
            scan.first = main_item;
        end
        else if (extra)
        begin
            scan.count            = 2'd2;
            scan.first.out_byte   = sjiscsv_pkg::WIDE_LEAD;
            scan.first.keep       = 1'b1;
            scan.first.restart    = 1'b0;
            scan.first.field_end  = 1'b0;
            scan.first.record_end = 1'b0;
            scan.first.run_last   = 1'b0;
        end
        else
        begin
            scan.count = 2'd1;
            scan.first = main_item;
        end
    end

endmodule

[hw/rtl/scfs_result_queue.sv]
// Three-entry shifting result queue that drives the result channel.
module scfs_result_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sjiscsv_pkg::scan_out_t scan,
    output logic                   space,
    output logic                   result_valid,
    input  logic                   result_ready,
    output sjiscsv_pkg::out_item_t result
);

    sjiscsv_pkg::out_item_t q_reg  [sjiscsv_pkg::QUEUE_DEPTH];
    sjiscsv_pkg::out_item_t q_next [sjiscsv_pkg::QUEUE_DEPTH];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] count_pop;
    logic [1:0] push_n;
    logic       pop;

    assign result_valid = (count_reg != 2'd0);
    assign result       = q_reg[0];
    assign space        = (count_reg <= 2'd1);
    assign pop          = result_valid && result_ready;

    always_comb
    begin
        q_next    = q_reg;
        count_pop = count_reg - {1'b0, pop};
        push_n    = push ? scan.count : 2'd0;
        if (pop)
        begin
            for (int i = 0; i < sjiscsv_pkg::QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < sjiscsv_pkg::QUEUE_DEPTH; i++)
        begin
            if ((push_n != 2'd0) && (2'(i) == count_pop))
            begin
                q_next[i] = scan.first;
            end
            if ((push_n == 2'd2) && (2'(i) == count_pop + 2'd1))
            begin
                q_next[i] = scan.second;
            end
        end
        count_next = count_pop + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

[hw/rtl/sjis_csv_field_splitter.sv]
// Top level of the Shift-JIS CSV field splitter.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_ready      sjiscsv_pkg::in_item_t
//  result    out        result_valid / result_ready  sjiscsv_pkg::out_item_t
//
// One byte transaction is accepted per cycle while item_ready is high; its
// results are registered in the result queue. A held 0x81 lead followed by a
// non-space byte yields two results, both pushed together into the three-entry queue.
// Input is accepted while the queue holds at most one result, so a stalled
// result side stops input once two or three results wait.
// Reset clears the field state and empties the queue.
module sjis_csv_field_splitter
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  sjiscsv_pkg::in_item_t  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output sjiscsv_pkg::out_item_t result
);

    sjiscsv_pkg::scan_out_t scan;
    logic                   accept;

    assign accept = item_valid && item_ready;

    scfs_scanner u_scanner
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .scan   (scan)
    );

    scfs_result_queue u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .scan         (scan),
        .space        (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[hw/rtl/scfs_checker.sv]
// Port checker of the field splitter and its bind to the top level.
`include "sjis_csv_field_splitter_assert.svh"

module scfs_checker
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_ready,
    input sjiscsv_pkg::out_item_t result
);

    `SCFS_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)
    `SCFS_ASSERT_NEXT(a_second_follows, clk, rst_n,
        result_valid && result_ready && !result.run_last, result_valid && result.run_last)
    `SCFS_ASSERT_NOW(a_record_ends_field, clk, rst_n,
        result_valid && result.record_end, result.field_end && result.run_last)
    `SCFS_ASSERT_NOW(a_held_lead_shape, clk, rst_n, result_valid && !result.run_last,
        (result.out_byte == sjiscsv_pkg::WIDE_LEAD) && result.keep && !result.field_end
        && !result.restart)

endmodule

bind sjis_csv_field_splitter scfs_checker u_checker (.*);

[tb/sv/sjis_csv_field_splitter_tb.sv]
// Self-checking testbench for the Shift-JIS CSV field splitter.
module sjis_csv_field_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_POINT_A = 26;
    localparam int DRAIN_POINT_B = 250;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PATTERN,
        RDY_SPARSE
    } ready_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    sjiscsv_pkg::in_item_t  item;
    logic                   result_valid;
    logic                   result_ready;
    sjiscsv_pkg::out_item_t result;

    sjiscsv_pkg::in_item_t  byte_stream_q[$];
    sjiscsv_pkg::out_item_t expected_q[$];

    logic                in_quotes;
    sjiscsv_pkg::phase_t phase;
    logic                literal_next;
    logic                lead_held;

    int          n_issued;
    int          n_taken;
    int          burst_left;
    int          gap_left;
    int          cycle_count;
    int          mismatches;
    ready_mode_t ready_mode;
    int          mode_left;
    logic [7:0]  stall_pattern;

    sjis_csv_field_splitter DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_field_state();
        in_quotes    = 1'b0;
        phase        = sjiscsv_pkg::PH_BLANK;
        literal_next = 1'b0;
        lead_held    = 1'b0;
    endfunction

    function automatic logic keeps_content();
        return (phase == sjiscsv_pkg::PH_CONTENT || phase == sjiscsv_pkg::PH_QUOTED);
    endfunction

    function automatic void split_byte(input sjiscsv_pkg::in_item_t it);
        logic [7:0] b;
        logic       last;
        logic       keep;
        logic       restart;
        logic       fend;
        b       = it.in_byte;
        last    = it.record_last;
        keep    = 1'b0;
        restart = 1'b0;
        fend    = last;
        if (lead_held)
        begin
            lead_held = 1'b0;
            if (b != sjiscsv_pkg::WIDE_SPACE)
            begin
                expected_q.push_back('{sjiscsv_pkg::WIDE_LEAD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
                keep  = 1'b1;
                phase = sjiscsv_pkg::PH_CONTENT;
            end
        end
        else if (literal_next)
        begin
            literal_next = 1'b0;
            keep = keeps_content();
        end
        else if ((b >= sjiscsv_pkg::LEAD_LOW_A && b <= sjiscsv_pkg::LEAD_HIGH_A)
                 || (b >= sjiscsv_pkg::LEAD_LOW_B && b <= sjiscsv_pkg::LEAD_HIGH_B)
                 || b == sjiscsv_pkg::CHAR_BSLASH)
        begin
            if (phase == sjiscsv_pkg::PH_BLANK && b == sjiscsv_pkg::WIDE_LEAD && !last)
            begin
                lead_held = 1'b1;
                return;
            end
            if (phase == sjiscsv_pkg::PH_BLANK)
                phase = sjiscsv_pkg::PH_CONTENT;
            keep = keeps_content();
            literal_next = 1'b1;
        end
        else if (b == sjiscsv_pkg::CHAR_COMMA && !in_quotes)
        begin
            fend  = 1'b1;
            phase = sjiscsv_pkg::PH_BLANK;
        end
        else if (b == sjiscsv_pkg::CHAR_QUOTE)
        begin
            in_quotes = ~in_quotes;
            if (phase == sjiscsv_pkg::PH_BLANK || phase == sjiscsv_pkg::PH_CONTENT)
            begin
                restart = 1'b1;
                phase   = sjiscsv_pkg::PH_QUOTED;
            end
            else if (phase == sjiscsv_pkg::PH_QUOTED)
                phase = sjiscsv_pkg::PH_AFTER;
        end
        else if (phase == sjiscsv_pkg::PH_BLANK
                 && (b == sjiscsv_pkg::CHAR_SPACE || b == sjiscsv_pkg::CHAR_TAB))
            keep = 1'b0;
        else
        begin
            if (phase == sjiscsv_pkg::PH_BLANK)
                phase = sjiscsv_pkg::PH_CONTENT;
            keep = keeps_content();
        end
        expected_q.push_back('{b, keep, restart, fend, last, 1'b1});
        if (last)
            clear_field_state();
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return sjiscsv_pkg::CHAR_COMMA;
            1:       return sjiscsv_pkg::CHAR_QUOTE;
            2:       return sjiscsv_pkg::CHAR_SPACE;
            3:       return 8'($urandom_range(0, 31));
            4:       return 8'($urandom_range(8'hA0, 8'hDF));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    function automatic void push_unit(ref logic [7:0] rec[$]);
        case ($urandom_range(0, 7))
            0:
            begin
                rec.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'h9F))
                                                   : 8'($urandom_range(8'hE0, 8'hFF)));
                rec.push_back(8'($urandom_range(8'h40, 8'hFC)));
            end
            1:
            begin
                rec.push_back(sjiscsv_pkg::CHAR_BSLASH);
                rec.push_back(8'($urandom_range(0, 255)));
            end
            2:
            begin
                rec.push_back(sjiscsv_pkg::WIDE_LEAD);
                rec.push_back($urandom_range(0, 1) ? sjiscsv_pkg::WIDE_SPACE
                                                   : 8'($urandom_range(0, 255)));
            end
            default: rec.push_back(pick_char());
        endcase
    endfunction

    function automatic void push_field(ref logic [7:0] rec[$]);
        int n;
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            case ($urandom_range(0, 2))
                0: rec.push_back(sjiscsv_pkg::CHAR_SPACE);
                1: rec.push_back(sjiscsv_pkg::CHAR_TAB);
                default:
                begin
                    rec.push_back(sjiscsv_pkg::WIDE_LEAD);
                    rec.push_back(sjiscsv_pkg::WIDE_SPACE);
                end
            endcase
        end
        case ($urandom_range(0, 3))
            0, 1:
            begin
                repeat ($urandom_range(0, 4))
                    push_unit(rec);
            end
            2:
            begin
                repeat ($urandom_range(0, 1))
                    push_unit(rec);
                rec.push_back(sjiscsv_pkg::CHAR_QUOTE);
                repeat ($urandom_range(0, 4))
                    push_unit(rec);
                if ($urandom_range(0, 5) != 0)
                    rec.push_back(sjiscsv_pkg::CHAR_QUOTE);
                repeat ($urandom_range(0, 2))
                    push_unit(rec);
            end
            default:
            begin
                repeat ($urandom_range(1, 5))
                    rec.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void push_record(ref logic [7:0] rec[$]);
        foreach (rec[i])
            byte_stream_q.push_back('{rec[i], i == rec.size() - 1});
    endfunction

    function automatic void build_stimulus();
        logic [7:0] rec[$];
        int         nfields;
        rec = '{8'h20, 8'h09, 8'h81, 8'h40, 8'h00, 8'h2C, 8'h81, 8'h5C, 8'h2C, 8'h41,
                8'h22, 8'h2C, 8'h5C, 8'h22, 8'h22, 8'h7F, 8'h22, 8'h2C, 8'h22, 8'hE0,
                8'h2C, 8'h2C};
        push_record(rec);
        rec = '{8'h81};
        push_record(rec);
        rec = '{8'h5C};
        push_record(rec);
        rec = '{8'hFF, 8'h9F};
        push_record(rec);
        while (byte_stream_q.size() < DRAIN_POINT_A + RANDOM_ITEMS)
        begin
            rec = {};
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    rec.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                nfields = $urandom_range(1, 5);
                for (int f = 0; f < nfields; f++)
                begin
                    push_field(rec);
                    if (f < nfields - 1 || $urandom_range(0, 4) == 0)
                        rec.push_back(sjiscsv_pkg::CHAR_COMMA);
                end
            end
            if (rec.size() == 0)
                rec.push_back(pick_char());
            push_record(rec);
        end
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && n_taken == n_issued)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (byte_stream_q.size() != 0
                     && !((n_issued == DRAIN_POINT_A || n_issued == DRAIN_POINT_B)
                          && expected_q.size() != 0))
            begin
                item       <= byte_stream_q.pop_front();
                item_valid <= 1'b1;
                n_issued++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                             : $urandom_range(0, 3);
                end
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left <= 0)
            begin
                ready_mode    = ready_mode_t'($urandom_range(0, 3));
                mode_left     = $urandom_range(20, 80);
                stall_pattern = 8'($urandom_range(1, 255));
            end
            mode_left--;
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            case (ready_mode)
                RDY_ALWAYS:  result_ready <= 1'b1;
                RDY_COIN:    result_ready <= 1'($urandom_range(0, 1));
                RDY_PATTERN: result_ready <= stall_pattern[0];
                default:     result_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        sjiscsv_pkg::out_item_t exp_item;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else
            begin
                if (item_valid && item_ready)
                begin
                    split_byte(item);
                    n_taken <= n_taken + 1;
                end
                if (result_valid && result_ready)
                begin
                    if (expected_q.size() == 0)
                    begin
                        $error("result transaction with no expected result: 0x%0h", result);
                        mismatches++;
                    end
                    else
                    begin
                        exp_item = expected_q.pop_front();
                        check_field("out_byte", exp_item.out_byte, result.out_byte);
                        check_field("keep", exp_item.keep, result.keep);
                        check_field("restart", exp_item.restart, result.restart);
                        check_field("field_end", exp_item.field_end, result.field_end);
                        check_field("record_end", exp_item.record_end, result.record_end);
                        check_field("run_last", exp_item.run_last, result.run_last);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        n_issued     = 0;
        n_taken      = 0;
        burst_left   = 8;
        gap_left     = 0;
        cycle_count  = 0;
        mismatches   = 0;
        mode_left    = 0;
        ready_mode   = RDY_ALWAYS;
        stall_pattern = 8'h5B;
        clear_field_state();
        build_stimulus();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (byte_stream_q.size() != 0 || n_taken != n_issued)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
